// ===== rtl/dfpe_pkg.sv =====
package dfpe_pkg;

    localparam int PAYLOAD_BYTES = 119;

    localparam int USED_W = ($clog2(PAYLOAD_BYTES) > 7) ? $clog2(PAYLOAD_BYTES) : 7;
    localparam int SUM_W  = ((USED_W > 10) ? USED_W : 10) + 1;

    localparam logic [1:0] CMD_BEGIN  = 2'd0;
    localparam logic [1:0] CMD_HEADER = 2'd1;
    localparam logic [1:0] CMD_ELEM   = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_W    = 2'd1;
    localparam logic [1:0] ST_NO_ROOM  = 2'd2;
    localparam logic [1:0] ST_NO_FIELD = 2'd3;

    localparam logic [2:0] HDR_BYTES = 3'd4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  elem_width;
        logic [7:0]  elem_count;
        logic [15:0] field_offset;
        logic        mode;
        logic [31:0] new_value;
        logic [31:0] old_value;
    } t_item;

    typedef struct packed {
        logic [USED_W-1:0] used_bytes;
        logic [4:0]        field_total;
        logic              field_open;
        logic [7:0]        elements_left;
        logic [2:0]        open_width;
        logic              open_mode;
    } t_state;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic [1:0]  status;
        logic [4:0]  fields_written;
        logic [6:0]  bytes_used;
    } t_result;

endpackage

// ===== rtl/dfpe_core.sv =====
module dfpe_core (
    input  dfpe_pkg::t_item   i_item,
    input  dfpe_pkg::t_state  i_state,
    output dfpe_pkg::t_state  o_state,
    output dfpe_pkg::t_result o_result
);

    logic                       w_width_ok;
    logic [1:0]                 w_shift;
    logic [dfpe_pkg::SUM_W-1:0] w_need;
    logic [dfpe_pkg::SUM_W-1:0] w_total;
    logic [31:0]                w_raw;
    logic [31:0]                w_mask;
    dfpe_pkg::t_state           w_next;
    logic [31:0]                w_word;
    logic [2:0]                 w_nbytes;
    logic [1:0]                 w_status;

    always_comb begin
        unique case (i_item.elem_width)
            8'd1: begin
                w_width_ok = 1'b1;
                w_shift    = 2'd0;
            end
            8'd2: begin
                w_width_ok = 1'b1;
                w_shift    = 2'd1;
            end
            8'd4: begin
                w_width_ok = 1'b1;
                w_shift    = 2'd2;
            end
            default: begin
                w_width_ok = 1'b0;
                w_shift    = 2'd0;
            end
        endcase
    end

    // width * count is a shift for the legal widths
    assign w_need  = (dfpe_pkg::SUM_W'(i_item.elem_count) << w_shift)
                   + dfpe_pkg::SUM_W'(dfpe_pkg::HDR_BYTES);
    assign w_total = w_need + dfpe_pkg::SUM_W'(i_state.used_bytes);

    assign w_raw = i_state.open_mode ? i_item.new_value
                                     : (i_item.new_value - i_item.old_value);

    always_comb begin
        unique case (i_state.open_width)
            3'd1:    w_mask = 32'h0000_00FF;
            3'd2:    w_mask = 32'h0000_FFFF;
            default: w_mask = 32'hFFFF_FFFF;
        endcase
    end

    always_comb begin
        w_next   = i_state;
        w_word   = 32'd0;
        w_nbytes = 3'd0;
        w_status = dfpe_pkg::ST_OK;
        unique case (i_item.cmd)
            dfpe_pkg::CMD_BEGIN: begin
                w_next.used_bytes    = '0;
                w_next.field_total   = '0;
                w_next.field_open    = 1'b0;
                w_next.elements_left = '0;
            end
            dfpe_pkg::CMD_HEADER: begin
                if (!w_width_ok) begin
                    w_status = dfpe_pkg::ST_BAD_W;
                end else if (w_total >= dfpe_pkg::SUM_W'(dfpe_pkg::PAYLOAD_BYTES)) begin
                    w_status = dfpe_pkg::ST_NO_ROOM;
                end else begin
                    w_next.field_total   = i_state.field_total + 5'd1;
                    w_next.used_bytes    = w_total[dfpe_pkg::USED_W-1:0];
                    w_word               = {i_item.field_offset, i_item.elem_count,
                                            i_item.elem_width};
                    w_nbytes             = dfpe_pkg::HDR_BYTES;
                    w_next.open_width    = i_item.elem_width[2:0];
                    w_next.open_mode     = i_item.mode;
                    w_next.elements_left = i_item.elem_count;
                    w_next.field_open    = (i_item.elem_count != 8'd0);
                end
            end
            dfpe_pkg::CMD_ELEM: begin
                if (!i_state.field_open || i_state.elements_left == 8'd0) begin
                    w_status = dfpe_pkg::ST_NO_FIELD;
                end else begin
                    w_word               = w_raw & w_mask;
                    w_nbytes             = i_state.open_width;
                    w_next.elements_left = i_state.elements_left - 8'd1;
                    w_next.field_open    = (i_state.elements_left != 8'd1);
                end
            end
            dfpe_pkg::CMD_NONE: begin
            end
            default: begin
            end
        endcase
    end

    assign o_state                 = w_next;
    assign o_result.data_word      = w_word;
    assign o_result.byte_count     = w_nbytes;
    assign o_result.status         = w_status;
    assign o_result.fields_written = w_next.field_total;
    assign o_result.bytes_used     = w_next.used_bytes[6:0];

endmodule

// ===== rtl/delta_field_packet_encoder_unit.sv =====
// Delta field packet encoder.
// Input channel (i_in_valid / o_in_ready) carries one command beat: begin
// packet, field header or field element. Output channel (o_out_valid /
// i_out_ready) returns exactly one result beat per input beat, in order:
// up to four payload bytes (little-endian, low byte first), their count,
// a status code and the running field and byte counts.
// An input register holds the beat, the encode logic runs from it and the
// packet state, and the result lands in the output register. Throughput:
// one beat per cycle while the receiver does not stall; the single encode
// stage, which also updates the packet state, sets it.
// Reset (i_rst_n low at a clock edge) empties both stages and clears the
// byte count, field count and open field.
// Receiver stall: the output register holds its beat; the input register
// still takes one more beat, then o_in_ready drops until the output drains.
module delta_field_packet_encoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_elem_width,
    input  logic [7:0]  i_elem_count,
    input  logic [15:0] i_field_offset,
    input  logic        i_mode,
    input  logic [31:0] i_new_value,
    input  logic [31:0] i_old_value,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_data_word,
    output logic [2:0]  o_byte_count,
    output logic [1:0]  o_status,
    output logic [4:0]  o_fields_written,
    output logic [6:0]  o_bytes_used
);

    logic              r_in_valid;
    dfpe_pkg::t_item   r_in;
    logic              r_out_valid;
    dfpe_pkg::t_result r_out;
    dfpe_pkg::t_state  r_state;
    dfpe_pkg::t_state  n_state;
    dfpe_pkg::t_result n_out;
    logic              w_adv;
    logic              w_take;

    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;
    assign w_take     = i_in_valid && o_in_ready;

    dfpe_core u_core (
        .i_item   (r_in),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in.cmd          <= i_cmd;
            r_in.elem_width   <= i_elem_width;
            r_in.elem_count   <= i_elem_count;
            r_in.field_offset <= i_field_offset;
            r_in.mode         <= i_mode;
            r_in.new_value    <= i_new_value;
            r_in.old_value    <= i_old_value;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_data_word      = r_out.data_word;
    assign o_byte_count     = r_out.byte_count;
    assign o_status         = r_out.status;
    assign o_fields_written = r_out.fields_written;
    assign o_bytes_used     = r_out.bytes_used;

    a_err_no_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status != dfpe_pkg::ST_OK |-> r_out.byte_count == 3'd0)
        else $error("error beat carries payload bytes");

    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.byte_count == 3'd0 |-> r_out.data_word == 32'd0)
        else $error("empty beat has nonzero data");

    a_open_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.field_open |-> r_state.elements_left != 8'd0)
        else $error("open field with no elements left");

    a_open_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.field_open |-> (r_state.open_width == 3'd1 || r_state.open_width == 3'd2
                                || r_state.open_width == 3'd4))
        else $error("open field has illegal width");

    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_state.used_bytes) < 32'(dfpe_pkg::PAYLOAD_BYTES))
        else $error("payload limit exceeded");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !i_out_ready |=> r_in_valid && $stable(r_in))
        else $error("input stage lost a beat under stall");

endmodule
